FILE: hw/rtl/iocsh_pkg.sv
// ----------------------------------------------------------------------------
// iocsh_pkg
// Types and constants shared by the I/O completion statistics block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package iocsh_pkg;

    // field widths
    localparam int OP_W    = 2;
    localparam int TYPE_W  = 2;
    localparam int SIZE_W  = 32;
    localparam int LAT_W   = 32;
    localparam int IDX_W   = 6;
    localparam int VALUE_W = 64;
    localparam int TOTAL_W = 64;
    localparam int THR_W   = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // request type codes
    localparam logic [TYPE_W-1:0] REQ_READ  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_WRITE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_SYNC  = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_OTHER = 2'd3;

    // read scope codes
    localparam logic READ_SCOPE_LAST   = 1'b0;
    localparam logic READ_SCOPE_GLOBAL = 1'b1;

    // storage scopes
    localparam int NUM_SCOPES = 3;
    localparam logic [1:0] SC_CUR  = 2'd0;
    localparam logic [1:0] SC_LAST = 2'd1;
    localparam logic [1:0] SC_GLOB = 2'd2;

    localparam int NUM_TYPES = 3;
    localparam int NUM_LAT   = 3;
    localparam int NUM_BINS  = 6;
    localparam int NUM_THR   = 5;
    localparam int BIN_W     = 3;

    // size counter selectors within a type group
    localparam logic [1:0] SZ_EVENTS = 2'd0;
    localparam logic [1:0] SZ_TOTAL  = 2'd1;
    localparam logic [1:0] SZ_MIN    = 2'd2;
    localparam logic [1:0] SZ_MAX    = 2'd3;

    // read index map
    localparam logic [IDX_W-1:0] IDX_LAT_BASE = 6'd12;
    localparam logic [IDX_W-1:0] IDX_LAT_LAST = 6'd32;
    localparam int LAT_STRIDE = 7;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_FIVE  = 3'd4;

    // threshold reset values in microseconds
    localparam int US_PER_MS = 1000;
    localparam logic [THR_W-1:0] THR_ONE_RST   = THR_W'(20 * US_PER_MS);
    localparam logic [THR_W-1:0] THR_TWO_RST   = THR_W'(50 * US_PER_MS);
    localparam logic [THR_W-1:0] THR_THREE_RST = THR_W'(100 * US_PER_MS);
    localparam logic [THR_W-1:0] THR_FOUR_RST  = THR_W'(200 * US_PER_MS);
    localparam logic [THR_W-1:0] THR_FIVE_RST  = THR_W'(500 * US_PER_MS);

    typedef logic [THR_W-1:0] t_thr [NUM_THR];

    // registered request
    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [TYPE_W-1:0] request_type;
        logic [SIZE_W-1:0] transfer_size;
        logic [LAT_W-1:0]  pending_latency;
        logic [LAT_W-1:0]  io_latency;
        logic [LAT_W-1:0]  network_latency;
        logic              read_scope;
        logic [IDX_W-1:0]  read_index;
    } t_req;

endpackage

FILE: hw/rtl/iocsh_req_if.sv
// ----------------------------------------------------------------------------
// iocsh_req_if
// Request channel of the I/O completion statistics block.
// ----------------------------------------------------------------------------
interface iocsh_req_if
    import iocsh_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TYPE_W-1:0] request_type;
    logic [SIZE_W-1:0] transfer_size;
    logic [LAT_W-1:0]  pending_latency;
    logic [LAT_W-1:0]  io_latency;
    logic [LAT_W-1:0]  network_latency;
    logic              read_scope;
    logic [IDX_W-1:0]  read_index;

    modport source (
        output valid, operation, request_type, transfer_size, pending_latency,
               io_latency, network_latency, read_scope, read_index,
        input  ready
    );

    modport sink (
        input  valid, operation, request_type, transfer_size, pending_latency,
               io_latency, network_latency, read_scope, read_index,
        output ready
    );
endinterface

FILE: hw/rtl/iocsh_rsp_if.sv
// ----------------------------------------------------------------------------
// iocsh_rsp_if
// Result channel of the I/O completion statistics block.
// ----------------------------------------------------------------------------
interface iocsh_rsp_if
    import iocsh_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] read_value;

    modport source (
        output valid, read_value,
        input  ready
    );

    modport sink (
        input  valid, read_value,
        output ready
    );
endinterface

FILE: hw/rtl/io_completion_stats_histogram.sv
// ----------------------------------------------------------------------------
// io_completion_stats_histogram
// Per-type I/O completion counters with min/max sizes and a six-bin latency
// histogram, kept for the current period, the last period and globally.
// ----------------------------------------------------------------------------
// The block takes one request per cycle unless the input side stalls. A
// request is captured in an input register and executed from there against
// the counter file: a completion updates the current-period counters, a
// period tick shifts current into last and merges it into global, and a read
// picks one last or global counter into the output register, from which its
// result is offered. The output register lets requests keep flowing while a
// result waits; the input side stalls only when a read sits in the input
// register and the output register is still held. There is no clearing
// pass: reset clears every counter at once.
// ----------------------------------------------------------------------------
module io_completion_stats_histogram
    import iocsh_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    iocsh_req_if.sink            i_req,
    iocsh_rsp_if.source          o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [THR_W-1:0]     i_cfg_data
);

    localparam int CW = COUNTER_WIDTH;
    localparam logic [CW-1:0] CNT_ONE = CW'(1);

    typedef logic [CW-1:0]      t_cnt_arr [NUM_SCOPES][NUM_TYPES];
    typedef logic [TOTAL_W-1:0] t_tot_arr [NUM_SCOPES][NUM_TYPES];
    typedef logic [SIZE_W-1:0]  t_sz_arr  [NUM_SCOPES][NUM_TYPES];
    typedef logic [CW-1:0]      t_lat_arr [NUM_SCOPES][NUM_LAT];
    typedef logic [CW-1:0]      t_bin_arr [NUM_SCOPES][NUM_LAT][NUM_BINS];

    // histogram bin of one latency sample
    function automatic logic [BIN_W-1:0] f_bin(input logic [LAT_W-1:0] v, input t_thr thr);
        logic [BIN_W-1:0] b;
        b = BIN_W'(NUM_BINS - 1);
        for (int i = NUM_THR - 1; i >= 0; i--) begin
            if (v <= thr[i]) begin
                b = BIN_W'(i);
            end
        end
        return b;
    endfunction

    t_thr     r_thr;
    t_cnt_arr r_evt, n_evt;
    t_tot_arr r_tot, n_tot;
    t_sz_arr  r_min, n_min;
    t_sz_arr  r_max, n_max;
    t_lat_arr r_lat, n_lat;
    t_bin_arr r_bin, n_bin;

    logic               r_stage_valid;
    t_req               r_stage;
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               n_out_valid;
    logic [VALUE_W-1:0] n_out_value;

    logic               w_adv;
    logic               w_fire;
    logic [VALUE_W-1:0] w_read_value;
    logic [LAT_W-1:0]   w_lat_val [NUM_LAT];
    logic [BIN_W-1:0]   w_lat_bin [NUM_LAT];

    // stage advances unless a read is blocked by a held result
    assign w_adv = !r_stage_valid || (r_stage.operation != OP_READ) ||
                   !r_out_valid || o_rsp.ready;
    assign w_fire = r_stage_valid && w_adv;
    assign i_req.ready = w_adv;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.read_value = r_out_value;

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[0] <= THR_ONE_RST;
            r_thr[1] <= THR_TWO_RST;
            r_thr[2] <= THR_THREE_RST;
            r_thr[3] <= THR_FOUR_RST;
            r_thr[4] <= THR_FIVE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THR_ONE:   r_thr[0] <= i_cfg_data;
                CFG_THR_TWO:   r_thr[1] <= i_cfg_data;
                CFG_THR_THREE: r_thr[2] <= i_cfg_data;
                CFG_THR_FOUR:  r_thr[3] <= i_cfg_data;
                CFG_THR_FIVE:  r_thr[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (w_adv) begin
            r_stage_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_req.valid) begin
            r_stage.operation       <= i_req.operation;
            r_stage.request_type    <= i_req.request_type;
            r_stage.transfer_size   <= i_req.transfer_size;
            r_stage.pending_latency <= i_req.pending_latency;
            r_stage.io_latency      <= i_req.io_latency;
            r_stage.network_latency <= i_req.network_latency;
            r_stage.read_scope      <= i_req.read_scope;
            r_stage.read_index      <= i_req.read_index;
        end
    end

    // bin selection for the three latencies
    assign w_lat_val[0] = r_stage.pending_latency;
    assign w_lat_val[1] = r_stage.io_latency;
    assign w_lat_val[2] = r_stage.network_latency;

    always_comb begin
        for (int l = 0; l < NUM_LAT; l++) begin
            w_lat_bin[l] = f_bin(w_lat_val[l], r_thr);
        end
    end

    // counter read mux
    always_comb begin
        logic [1:0]  sc;
        logic [1:0]  ty;
        logic [4:0]  r;
        logic [1:0]  ls;
        logic [2:0]  k;
        sc = (r_stage.read_scope == READ_SCOPE_GLOBAL) ? SC_GLOB : SC_LAST;
        ty = r_stage.read_index[3:2];
        r  = 5'(r_stage.read_index - IDX_LAT_BASE);
        if (r < 5'(LAT_STRIDE)) begin
            ls = 2'd0;
        end else if (r < 5'(2 * LAT_STRIDE)) begin
            ls = 2'd1;
        end else begin
            ls = 2'd2;
        end
        k = 3'(r - 5'(ls * 5'(LAT_STRIDE)));
        w_read_value = '0;
        if (r_stage.read_index < IDX_LAT_BASE) begin
            case (r_stage.read_index[1:0])
                SZ_EVENTS: w_read_value = VALUE_W'(r_evt[sc][ty]);
                SZ_TOTAL:  w_read_value = r_tot[sc][ty];
                SZ_MIN:    w_read_value = VALUE_W'(r_min[sc][ty]);
                SZ_MAX:    w_read_value = VALUE_W'(r_max[sc][ty]);
                default:   w_read_value = '0;
            endcase
        end else if (r_stage.read_index <= IDX_LAT_LAST) begin
            if (k == 3'd0) begin
                w_read_value = VALUE_W'(r_lat[sc][ls]);
            end else begin
                w_read_value = VALUE_W'(r_bin[sc][ls][k - 3'd1]);
            end
        end
    end

    // counter file update
    always_comb begin
        logic [TYPE_W-1:0] ty;
        logic [SIZE_W-1:0] v;
        n_evt = r_evt;
        n_tot = r_tot;
        n_min = r_min;
        n_max = r_max;
        n_lat = r_lat;
        n_bin = r_bin;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_value = r_out_value;
        ty = r_stage.request_type;
        v  = (ty == REQ_SYNC) ? '0 : r_stage.transfer_size;
        if (w_fire) begin
            case (r_stage.operation)
                OP_RECORD: begin
                    // byte statistics of the request type
                    if (ty != REQ_OTHER) begin
                        if (r_evt[SC_CUR][ty] == '0) begin
                            n_min[SC_CUR][ty] = v;
                            n_max[SC_CUR][ty] = v;
                        end else if (v < r_min[SC_CUR][ty]) begin
                            n_min[SC_CUR][ty] = v;
                        end else if (v > r_max[SC_CUR][ty]) begin
                            n_max[SC_CUR][ty] = v;
                        end
                        n_tot[SC_CUR][ty] = r_tot[SC_CUR][ty] + TOTAL_W'(v);
                        n_evt[SC_CUR][ty] = r_evt[SC_CUR][ty] + CNT_ONE;
                    end
                    // latency histograms
                    for (int l = 0; l < NUM_LAT; l++) begin
                        n_lat[SC_CUR][l] = r_lat[SC_CUR][l] + CNT_ONE;
                        n_bin[SC_CUR][l][w_lat_bin[l]] =
                            r_bin[SC_CUR][l][w_lat_bin[l]] + CNT_ONE;
                    end
                end
                OP_TICK: begin
                    for (int t = 0; t < NUM_TYPES; t++) begin
                        // shift current into last and clear current
                        n_evt[SC_LAST][t] = r_evt[SC_CUR][t];
                        n_tot[SC_LAST][t] = r_tot[SC_CUR][t];
                        n_min[SC_LAST][t] = r_min[SC_CUR][t];
                        n_max[SC_LAST][t] = r_max[SC_CUR][t];
                        n_evt[SC_CUR][t]  = '0;
                        n_tot[SC_CUR][t]  = '0;
                        n_min[SC_CUR][t]  = '0;
                        n_max[SC_CUR][t]  = '0;
                        // merge the closed period into global
                        if (r_evt[SC_CUR][t] != '0) begin
                            if (r_evt[SC_GLOB][t] == '0) begin
                                n_evt[SC_GLOB][t] = r_evt[SC_CUR][t];
                                n_tot[SC_GLOB][t] = r_tot[SC_CUR][t];
                                n_min[SC_GLOB][t] = r_min[SC_CUR][t];
                                n_max[SC_GLOB][t] = r_max[SC_CUR][t];
                            end else begin
                                if (r_min[SC_CUR][t] < r_min[SC_GLOB][t]) begin
                                    n_min[SC_GLOB][t] = r_min[SC_CUR][t];
                                end
                                if (r_max[SC_CUR][t] > r_max[SC_GLOB][t]) begin
                                    n_max[SC_GLOB][t] = r_max[SC_CUR][t];
                                end
                                n_tot[SC_GLOB][t] = r_tot[SC_GLOB][t] + r_tot[SC_CUR][t];
                                n_evt[SC_GLOB][t] = r_evt[SC_GLOB][t] + r_evt[SC_CUR][t];
                            end
                        end
                    end
                    for (int l = 0; l < NUM_LAT; l++) begin
                        n_lat[SC_LAST][l] = r_lat[SC_CUR][l];
                        n_lat[SC_CUR][l]  = '0;
                        for (int b = 0; b < NUM_BINS; b++) begin
                            n_bin[SC_LAST][l][b] = r_bin[SC_CUR][l][b];
                            n_bin[SC_CUR][l][b]  = '0;
                        end
                        if (r_lat[SC_CUR][l] != '0) begin
                            if (r_lat[SC_GLOB][l] == '0) begin
                                n_lat[SC_GLOB][l] = r_lat[SC_CUR][l];
                                for (int b = 0; b < NUM_BINS; b++) begin
                                    n_bin[SC_GLOB][l][b] = r_bin[SC_CUR][l][b];
                                end
                            end else begin
                                n_lat[SC_GLOB][l] = r_lat[SC_GLOB][l] + r_lat[SC_CUR][l];
                                for (int b = 0; b < NUM_BINS; b++) begin
                                    n_bin[SC_GLOB][l][b] =
                                        r_bin[SC_GLOB][l][b] + r_bin[SC_CUR][l][b];
                                end
                            end
                        end
                    end
                end
                OP_READ: begin
                    n_out_valid = 1'b1;
                    n_out_value = w_read_value;
                end
                default: ;
            endcase
        end
    end

    // counter file registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SCOPES; s++) begin
                for (int t = 0; t < NUM_TYPES; t++) begin
                    r_evt[s][t] <= '0;
                    r_tot[s][t] <= '0;
                    r_min[s][t] <= '0;
                    r_max[s][t] <= '0;
                end
                for (int l = 0; l < NUM_LAT; l++) begin
                    r_lat[s][l] <= '0;
                    for (int b = 0; b < NUM_BINS; b++) begin
                        r_bin[s][l][b] <= '0;
                    end
                end
            end
        end else begin
            r_evt <= n_evt;
            r_tot <= n_tot;
            r_min <= n_min;
            r_max <= n_max;
            r_lat <= n_lat;
            r_bin <= n_bin;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value <= n_out_value;
    end

    // checks
    logic w_minmax_ok;
    logic w_cur_empty;
    logic w_fire_tick;
    logic w_fire_read;

    assign w_fire_tick = w_fire && (r_stage.operation == OP_TICK);
    assign w_fire_read = w_fire && (r_stage.operation == OP_READ);

    always_comb begin
        w_minmax_ok = 1'b1;
        w_cur_empty = 1'b1;
        for (int s = 0; s < NUM_SCOPES; s++) begin
            for (int t = 0; t < NUM_TYPES; t++) begin
                if ((r_evt[s][t] != '0) && (r_min[s][t] > r_max[s][t])) begin
                    w_minmax_ok = 1'b0;
                end
            end
        end
        for (int t = 0; t < NUM_TYPES; t++) begin
            if (r_evt[SC_CUR][t] != '0) begin
                w_cur_empty = 1'b0;
            end
        end
        for (int l = 0; l < NUM_LAT; l++) begin
            if (r_lat[SC_CUR][l] != '0) begin
                w_cur_empty = 1'b0;
            end
        end
    end

    // minimum never exceeds maximum in a nonempty slot
    a_minmax_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_minmax_ok)
        else $error("size minimum above maximum");

    // a period tick leaves the current period empty
    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire_tick |=> w_cur_empty)
        else $error("current period not cleared by tick");

    // a result appears only for an executed read
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_fire_read))
        else $error("result without read request");

    // a blocked request is held in the input register
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage_valid && !w_adv) |=> (r_stage_valid && $stable(r_stage)))
        else $error("blocked request lost");

endmodule
